### hw/rtl/indexed_ordered_list_engine_unit_assert.svh
// Assertion macros used by the ordered list engine top level.
`ifndef INDEXED_ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH
`define INDEXED_ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTH
`define IOLE_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("ordered list engine check failed");
`define IOLE_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ordered list engine check failed");
`define IOLE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ordered list engine check failed");
`else
`define IOLE_ASSERT_ALWAYS(lbl, expr)
`define IOLE_ASSERT_SAME(lbl, ante, cons)
`define IOLE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/iole_pkg.sv
// Types and constants shared by the ordered list engine modules.
`timescale 1ns / 1ps
package iole_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_W     = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int POS_W      = 7;
   localparam int REQ_W      = 3;
   localparam int ST_W       = 2;
   localparam int GROUP_SIZE = 8;
   localparam int NGROUP     = CAPACITY / GROUP_SIZE;
   localparam int GRP_IDX_W  = $clog2(GROUP_SIZE);

   localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd4;
   localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd5;
   localparam logic [REQ_W-1:0] REQ_FIND       = 3'd6;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [CNT_W-1:0]   at;
      logic [DATA_W-1:0]  value;
      logic [CNT_W-1:0]   count;
      logic [CNT_W-1:0]   last_at;
      logic               capture;
   } cell_ctrl_type;

   typedef struct packed {
      logic [DATA_W-1:0]  data;
      logic               match;
      logic               last;
   } cell_view_type;

   typedef struct packed {
      logic                  any;
      logic [GRP_IDX_W-1:0]  idx;
      logic [DATA_W-1:0]     back;
   } grp_sum_type;

endpackage

### hw/rtl/iole_cell.sv
// One storage cell of the list: holds a word and shifts with its neighbors.
`timescale 1ns / 1ps
module iole_cell (
   input  logic                         clock,
   input  logic [iole_pkg::CNT_W-1:0]   cell_index,
   input  iole_pkg::cell_ctrl_type      ctrl,
   input  logic [iole_pkg::DATA_W-1:0]  left_data,
   input  logic [iole_pkg::DATA_W-1:0]  right_data,
   output iole_pkg::cell_view_type      view
);
   import iole_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              match_ff;
   logic              match_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (cell_index == ctrl.at) begin
               data_in = ctrl.value;
            end else if (cell_index > ctrl.at) begin
               data_in = left_data;
            end
         end
         CELL_REMOVE: begin
            if (cell_index >= ctrl.at) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   assign match_in = ctrl.capture ? ((data_ff == ctrl.value) && (cell_index < ctrl.count))
                                  : match_ff;

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign view.data  = data_ff;
   assign view.match = match_ff;
   assign view.last  = (cell_index == ctrl.last_at);

endmodule

### hw/rtl/iole_group.sv
// Registered reduction over one group of cells: first match and tail word.
`timescale 1ns / 1ps
module iole_group (
   input  logic                                                 clock,
   input  iole_pkg::cell_view_type [iole_pkg::GROUP_SIZE-1:0]  views,
   output iole_pkg::grp_sum_type                                sum
);
   import iole_pkg::*;

   grp_sum_type sum_ff;
   grp_sum_type sum_in;

   always_comb begin
      sum_in.any  = 1'b0;
      sum_in.idx  = '0;
      sum_in.back = '0;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
         if (views[i].match) begin
            sum_in.any = 1'b1;
            sum_in.idx = GRP_IDX_W'(i);
         end
      end
      for (int i = 0; i < GROUP_SIZE; i++) begin
         sum_in.back = sum_in.back | (views[i].data & {DATA_W{views[i].last}});
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule

### hw/rtl/indexed_ordered_list_engine_unit.sv
// Top level of the ordered list engine: request decode, cell row and result stage.
//
// Usage:
// The request channel (req_valid, req_stall) carries one word per request: a request
// type, a position and a value. The response channel (rsp_valid, rsp_stall) returns
// one word per request with the status, the found position, the front and back
// values, the entry count and the empty flag, all as they stand after the request.
// The list lives in a row of 64 cells that shift toward the back on an insert and
// toward the front on a remove, all in the cycle the request is accepted.
// Each cell compares its word with the request value in that same cycle.
// The first match and the tail word are then gathered through a two-level
// registered tree, eight cells per group in the first level.
// rsp_valid rises once the request has passed the s1 and s2 stage registers, and the response can be
// taken at the edge where the next request is accepted.
// req_stall stays high while a request is inside the tree.
// When the receiver stalls, the response holds and the request in flight waits at
// the last tree stage, so the request channel stalls as well.
// Reset empties the list and clears the handshake state; no clearing pass is needed.
`timescale 1ns / 1ps
`include "indexed_ordered_list_engine_unit_assert.svh"
module indexed_ordered_list_engine_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [iole_pkg::REQ_W-1:0]   req_type,
   input  logic [iole_pkg::POS_W-1:0]   req_position,
   input  logic [iole_pkg::DATA_W-1:0]  req_item_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [iole_pkg::ST_W-1:0]    rsp_status,
   output logic [iole_pkg::CNT_W-1:0]   rsp_found_index,
   output logic [iole_pkg::DATA_W-1:0]  rsp_front_value,
   output logic [iole_pkg::DATA_W-1:0]  rsp_back_value,
   output logic [iole_pkg::CNT_W-1:0]   rsp_entry_count,
   output logic                         rsp_is_empty
);
   import iole_pkg::*;

   logic                        accept;
   logic                        full;
   logic                        empty;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic [CNT_W-1:0]            pos_ext;
   cell_op_type                 op;
   logic [CNT_W-1:0]            op_at;
   logic [ST_W-1:0]             status;
   cell_ctrl_type               ctrl;
   cell_view_type [CAPACITY-1:0] views;
   grp_sum_type                 sums [NGROUP];

   logic                        s1_ff;
   logic                        s1_in;
   logic                        s2_ff;
   logic                        s2_in;
   logic [ST_W-1:0]             st1_ff;
   logic [ST_W-1:0]             st2_ff;
   logic                        find1_ff;
   logic                        find2_ff;
   logic                        move;
   logic                        grow_req;

   logic [CNT_W-1:0]            found;
   logic [DATA_W-1:0]           back;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [ST_W-1:0]             rsp_status_ff;
   logic [CNT_W-1:0]            rsp_found_ff;
   logic [DATA_W-1:0]           rsp_front_ff;
   logic [DATA_W-1:0]           rsp_back_ff;
   logic [CNT_W-1:0]            rsp_count_ff;
   logic                        rsp_empty_ff;

   assign req_stall = s1_ff | s2_ff;
   assign accept    = req_valid & ~req_stall;
   assign full      = (count_ff >= CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign pos_ext   = CNT_W'(req_position);
   assign grow_req  = accept & ~full &
                      (req_type inside {REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT});

   always_comb begin
      op       = CELL_HOLD;
      op_at    = '0;
      status   = ST_OK;
      count_in = count_ff;
      case (req_type)
         REQ_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               op       = CELL_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               op       = CELL_INSERT;
               op_at    = count_ff;
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_POP_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               op       = CELL_REMOVE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         REQ_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         REQ_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               op       = CELL_INSERT;
               op_at    = (pos_ext >= count_ff) ? count_ff : pos_ext;
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_REMOVE: begin
            if (pos_ext >= count_ff) begin
               status = ST_RANGE;
            end else begin
               op       = CELL_REMOVE;
               op_at    = pos_ext;
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            op = CELL_HOLD;
         end
      endcase
   end

   assign ctrl.op      = accept ? op : CELL_HOLD;
   assign ctrl.at      = op_at;
   assign ctrl.value   = req_item_value;
   assign ctrl.count   = count_ff;
   assign ctrl.last_at = count_ff - CNT_W'(1);
   assign ctrl.capture = accept;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_word;
      logic [DATA_W-1:0] right_word;
      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_left
         assign left_word = views[i-1].data;
      end
      if (i == CAPACITY - 1) begin : g_end
         assign right_word = '0;
      end else begin : g_right
         assign right_word = views[i+1].data;
      end
      iole_cell u_cell (
         .clock      (clock),
         .cell_index (CNT_W'(i)),
         .ctrl       (ctrl),
         .left_data  (left_word),
         .right_data (right_word),
         .view       (views[i])
      );
   end

   for (genvar g = 0; g < NGROUP; g++) begin : g_group
      iole_group u_group (
         .clock (clock),
         .views (views[g*GROUP_SIZE +: GROUP_SIZE]),
         .sum   (sums[g])
      );
   end

   always_comb begin
      found = count_ff;
      back  = '0;
      for (int g = NGROUP - 1; g >= 0; g--) begin
         if (sums[g].any) begin
            found = CNT_W'(g * GROUP_SIZE + int'(sums[g].idx));
         end
      end
      for (int g = 0; g < NGROUP; g++) begin
         back = back | sums[g].back;
      end
   end

   assign move         = s2_ff & (~rsp_valid_ff | ~rsp_stall);
   assign s1_in        = accept;
   assign s2_in        = s1_ff | (s2_ff & ~move);
   assign rsp_valid_in = move | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st1_ff   <= status;
         find1_ff <= (req_type == REQ_FIND);
      end
      if (s1_ff) begin
         st2_ff   <= st1_ff;
         find2_ff <= find1_ff;
      end
      if (move) begin
         rsp_status_ff <= st2_ff;
         rsp_found_ff  <= find2_ff ? found : '0;
         rsp_front_ff  <= empty ? '0 : views[0].data;
         rsp_back_ff   <= back;
         rsp_count_ff  <= count_ff;
         rsp_empty_ff  <= empty;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;

   `IOLE_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(CAPACITY))
   `IOLE_ASSERT_ALWAYS(a_one_in_flight, $onehot0({s1_ff, s2_ff}))
   `IOLE_ASSERT_NEXT(a_push_grows, grow_req, count_ff == $past(count_ff) + CNT_W'(1))
   `IOLE_ASSERT_NEXT(a_stall_holds_item, s2_ff && rsp_valid_ff && rsp_stall, s2_ff && req_stall)
   `IOLE_ASSERT_SAME(a_empty_flag, rsp_valid_ff, rsp_empty_ff == (rsp_count_ff == '0))

endmodule
